/* src/fpl_pkg.sv */
// ----------------------------------------------------------------------------
// fpl_pkg: shared types and constants of the four-pole ladder filter
// fixed point formats, sequencer steps, state codes and saturation helpers
// ----------------------------------------------------------------------------
package fpl_pkg;

  localparam int unsigned FPL_CHANNELS = 2;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned CUTOFF_W   = 16;
  localparam int unsigned RES_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STATE_W    = 32;
  localparam int unsigned OP_W       = 33;
  localparam int unsigned PROD_W     = 2 * OP_W;
  localparam int unsigned WIDE_W     = 36;

  typedef logic signed [OP_W-1:0]    fpl_op_t;
  typedef logic signed [PROD_W-1:0]  fpl_prod_t;
  typedef logic signed [WIDE_W-1:0]  fpl_wide_t;
  typedef logic signed [STATE_W-1:0] fpl_word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESONANCE = 1'b0,
    CFG_HIGHPASS  = 1'b1
  } fpl_cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } fpl_state_e;

  // sequencer step: step k issues multiplication k and retires k-1
  typedef logic [4:0] fpl_step_t;

  localparam fpl_step_t STP_CUT  = 5'd0;
  localparam fpl_step_t STP_IN0  = 5'd1;
  localparam fpl_step_t STP_FF   = 5'd2;
  localparam fpl_step_t STP_IN1  = 5'd3;
  localparam fpl_step_t STP_T    = 5'd4;
  localparam fpl_step_t STP_FF2  = 5'd5;
  localparam fpl_step_t STP_FB   = 5'd6;
  localparam fpl_step_t STP_G    = 5'd7;
  localparam fpl_step_t STP_FBK  = 5'd8;
  localparam fpl_step_t STP_IN2  = 5'd9;
  localparam fpl_step_t STP_GAIN = 5'd10;
  localparam fpl_step_t STP_Y0   = 5'd11;
  localparam fpl_step_t STP_Y1   = 5'd12;
  localparam fpl_step_t STP_Y2   = 5'd13;
  localparam fpl_step_t STP_IN3  = 5'd14;
  localparam fpl_step_t STP_Y3   = 5'd15;
  localparam fpl_step_t STP_TAIL = 5'd16;
  localparam fpl_step_t STP_OUT  = 5'd17;

  // coefficients
  localparam fpl_op_t K_116   = 33'sd76022;      // 1.16 in Q16
  localparam fpl_op_t K_015   = 33'sd9830;       // 0.15 in Q16
  localparam fpl_op_t K_GAIN  = 33'sd22946;      // 0.35013 in Q16
  localparam fpl_op_t K_03    = 33'sd322122547;  // 0.3 in Q30
  localparam fpl_op_t ONE_Q30 = 33'sd1073741824;

  localparam fpl_wide_t W_MAX32 = 36'sd2147483647;
  localparam fpl_wide_t W_MIN32 = -36'sd2147483648;
  localparam fpl_word_t W_MAX24 = 32'sd8388607;
  localparam fpl_word_t W_MIN24 = -32'sd8388608;

  function automatic fpl_word_t sat32(input fpl_wide_t v);
    fpl_word_t r;
    if (v > W_MAX32) begin
      r = 32'sh7fffffff;
    end else if (v < W_MIN32) begin
      r = 32'sh80000000;
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input fpl_word_t v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > W_MAX24) begin
      r = 24'sh7fffff;
    end else if (v < W_MIN24) begin
      r = 24'sh800000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/fpl_in_if.sv */
// ----------------------------------------------------------------------------
// fpl_in_if: sample input channel
// valid/ready handshake carrying one sample, its channel and the cutoff
// ----------------------------------------------------------------------------
interface fpl_in_if import fpl_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       channel;
  logic [CUTOFF_W-1:0]        cutoff;

  modport source (output valid, output sample_in, output channel, output cutoff,
                  input ready);
  modport sink   (input valid, input sample_in, input channel, input cutoff,
                  output ready);

endinterface

/* src/fpl_out_if.sv */
// ----------------------------------------------------------------------------
// fpl_out_if: filtered sample output channel
// valid/ready handshake carrying one filtered sample and its channel
// ----------------------------------------------------------------------------
interface fpl_out_if import fpl_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       out_channel;

  modport source (output valid, output sample_out, output out_channel, input ready);
  modport sink   (input valid, input sample_out, input out_channel, output ready);

endinterface

/* src/four_pole_ladder_filter_top.sv */
// ----------------------------------------------------------------------------
// four_pole_ladder_filter_top: resonant four-pole ladder filter
// sequencing: the single 33x33 multiplier runs the 16 multiplications of a
//   sample one after the other; a new request is taken only while idle, once the
//   previous result has been handed to a free or ready output register
// reset: asynchronous, clears config, sequencer, output valid and all pole
//   state at once; the block is ready straight out of reset
// ----------------------------------------------------------------------------
module four_pole_ladder_filter_top import fpl_pkg::*; #(
  parameter int unsigned CHANNELS = FPL_CHANNELS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fpl_in_if.sink                in_i,
  fpl_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = 4 * CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // config
  logic [RES_W-1:0] res_q;
  logic             hp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
      hp_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (fpl_cfg_idx_e'(cfg_idx_i))
        CFG_RESONANCE: res_q <= cfg_data_i;
        CFG_HIGHPASS:  hp_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  fpl_state_e state_q, state_d;
  fpl_step_t  step_q;
  logic       in_ready, busy, in_fire, done, out_valid_q;

  always_comb begin
    in_ready = 1'b0;
    busy     = 1'b0;
    case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN:  busy     = 1'b1;
      default: ;
    endcase
  end

  assign in_fire = in_i.valid && in_ready;
  assign done    = busy && (step_q == STP_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_RUN;
      ST_RUN:  if (done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STP_CUT;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        step_q <= STP_CUT;
      end else if (busy && step_q != STP_OUT) begin
        step_q <= step_q + 5'd1;
      end
    end
  end

  // captured request
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [CUTOFF_W-1:0]        cut_q;
  logic                       ch_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_i.sample_in;
      cut_q    <= in_i.cutoff;
      ch_q     <= in_i.channel;
    end
  end

  assign in_i.ready = in_ready;

  fpl_wide_t s26_w;
  assign s26_w = {{8{sample_q[SAMPLE_W-1]}}, sample_q, 4'b0000};

  // pole state, entry 4*channel + pole
  fpl_word_t pin_q  [DEPTH];
  fpl_word_t pout_q [DEPTH];
  logic [1:0]    rd_pole, wr_pole;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          pole_we;
  fpl_word_t     pin_rd, pout_rd;

  // pole read by the multiplication issued in this step
  always_comb begin
    case (step_q)
      STP_IN1, STP_Y1:          rd_pole = 2'd1;
      STP_IN2, STP_Y2:          rd_pole = 2'd2;
      STP_IN3, STP_Y3, STP_FBK: rd_pole = 2'd3;
      default:                  rd_pole = 2'd0;
    endcase
  end

  // pole whose output is retired in this step
  always_comb begin
    case (step_q)
      STP_Y2:   wr_pole = 2'd1;
      STP_IN3:  wr_pole = 2'd2;
      STP_TAIL: wr_pole = 2'd3;
      default:  wr_pole = 2'd0;
    endcase
  end

  // channels beyond the store wrap through the address truncation
  assign rd_addr = AW'({ch_q, rd_pole});
  assign wr_addr = AW'({ch_q, wr_pole});
  assign pin_rd  = pin_q[rd_addr];
  assign pout_rd = pout_q[rd_addr];

  // working registers
  logic [30:0] f_q, f_d, ff_q, ff_d, tmp_q, tmp_d;
  fpl_word_t   finv_q, finv_d, x_q, x_d;
  fpl_op_t     fb_q, fb_d;
  logic [29:0] g_q, g_d;
  fpl_word_t   p_q [4];
  fpl_word_t   p_d [4];

  // shared multiplier
  fpl_op_t   mul_a, mul_b;
  fpl_prod_t prod;
  fpl_wide_t prod_fl30;

  fpl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_fl30 = prod[PROD_W-1:30];

  // operand selection per step
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    case (step_q)
      STP_CUT: begin
        mul_a = {17'b0, cut_q};
        mul_b = K_116;
      end
      STP_IN0, STP_IN1, STP_IN2, STP_IN3: begin
        mul_a = {pin_rd[STATE_W-1], pin_rd};
        mul_b = K_03;
      end
      STP_FF: begin
        mul_a = {2'b00, f_q};
        mul_b = {2'b00, f_q};
      end
      STP_T: begin
        mul_a = {2'b00, ff_q};
        mul_b = K_015;
      end
      STP_FF2: begin
        mul_a = {2'b00, ff_q};
        mul_b = {2'b00, ff_q};
      end
      STP_FB: begin
        mul_a = {17'b0, res_q};
        mul_b = ONE_Q30 - {2'b00, tmp_q};
      end
      STP_G: begin
        mul_a = {2'b00, tmp_q};
        mul_b = K_GAIN;
      end
      STP_FBK: begin
        mul_a   = {pout_rd[STATE_W-1], pout_rd};
        mul_b   = fb_q;
      end
      STP_GAIN: begin
        mul_a = {x_q[STATE_W-1], x_q};
        mul_b = {3'b000, g_q};
      end
      STP_Y0, STP_Y1, STP_Y2, STP_Y3: begin
        mul_a = {pout_rd[STATE_W-1], pout_rd};
        mul_b = {finv_q[STATE_W-1], finv_q};
      end
      default: ;
    endcase
  end

  // retire the product issued in the previous step
  fpl_word_t pole_y;
  assign pole_y = sat32({{4{x_q[STATE_W-1]}}, x_q}
                        + {{4{p_q[wr_pole][STATE_W-1]}}, p_q[wr_pole]} + prod_fl30);

  always_comb begin
    f_d     = f_q;
    finv_d  = finv_q;
    ff_d    = ff_q;
    tmp_d   = tmp_q;
    fb_d    = fb_q;
    g_d     = g_q;
    x_d     = x_q;
    p_d     = p_q;
    pole_we = 1'b0;
    if (busy) begin
      case (step_q)
        STP_IN0: begin
          f_d    = prod[32:2];
          finv_d = 32'sd1073741824 - $signed({1'b0, prod[32:2]});
        end
        STP_FF:   p_d[0] = prod_fl30[STATE_W-1:0];
        STP_IN1:  ff_d   = prod[60:30];
        STP_T:    p_d[1] = prod_fl30[STATE_W-1:0];
        STP_FF2:  tmp_d  = prod[46:16];   // 0.15 * f^2
        STP_FB:   tmp_d  = prod[60:30];   // f^4
        STP_G:    fb_d   = prod[46:14];
        STP_FBK:  g_d    = prod[45:16];
        STP_IN2:  x_d    = sat32(s26_w - prod_fl30);   // resonance feedback
        STP_GAIN: p_d[2] = prod_fl30[STATE_W-1:0];
        STP_Y0:   x_d    = sat32(prod_fl30);
        STP_Y3:   p_d[3] = prod_fl30[STATE_W-1:0];
        STP_Y1, STP_Y2, STP_IN3, STP_TAIL: begin
          pole_we = 1'b1;
          x_d     = pole_y;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    finv_q <= finv_d;
    ff_q   <= ff_d;
    tmp_q  <= tmp_d;
    fb_q   <= fb_d;
    g_q    <= g_d;
    x_q    <= x_d;
    p_q    <= p_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        pin_q[i]  <= '0;
        pout_q[i] <= '0;
      end
    end else if (pole_we) begin
      // x_q still holds this pole's input
      pin_q[wr_addr]  <= x_q;
      pout_q[wr_addr] <= pole_y;
    end
  end

  // result
  fpl_wide_t                  res_v;
  logic signed [SAMPLE_W-1:0] sample_out_q;
  logic                       out_ch_q;

  assign res_v = hp_q ? (s26_w - {{4{x_q[STATE_W-1]}}, x_q})
                      : {{4{x_q[STATE_W-1]}}, x_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      sample_out_q <= sat24(res_v[WIDE_W-1:4]);
      out_ch_q     <= ch_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.sample_out  = sample_out_q;
  assign out_o.out_channel = out_ch_q;

  // checks
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_RUN) && (step_q == STP_CUT))
    else $error("sequencer did not start after request");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STP_OUT)
    else $error("step counter ran past the last step");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RUN && step_q == STP_OUT))
    else $error("result appeared outside the final step");

  a_out_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (out_ch_q == ch_q))
    else $error("result channel differs from request channel");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready && busy && step_q == STP_OUT) |=> (state_q == ST_RUN))
    else $error("pending result overwritten");

endmodule

/* src/fpl_mul.sv */
// ----------------------------------------------------------------------------
// fpl_mul: shared signed multiplier
// one 33x33 signed multiply per cycle, product registered
// ----------------------------------------------------------------------------
module fpl_mul import fpl_pkg::*; (
  input  logic      clk_i,
  input  fpl_op_t   a_i,
  input  fpl_op_t   b_i,
  output fpl_prod_t p_o
);

  fpl_prod_t prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign p_o = prod_q;

endmodule
